// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL. Each module that uses them has
// i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/kufec_pkg.sv =====
`default_nettype none

package kufec_pkg;

    localparam int VERTICES_DEF  = 1024;
    localparam int VERTEX_W      = 10;
    localparam int INDEX_W       = 16;
    localparam int CLASS_W       = 2;
    localparam int VCOUNT_W      = 11;
    localparam int RANK_W        = 4;
    localparam logic [RANK_W-1:0]   RANK_MAX      = 4'd15;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET  = 11'd1024;

    localparam logic [CLASS_W-1:0] CLS_FOREST  = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_CYCLE   = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_INVALID = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_CLEAR   = 2'd3;

    typedef logic [3:0] t_step;

    localparam t_step ST_BOOT     = 4'd0;
    localparam t_step ST_IDLE     = 4'd1;
    localparam t_step ST_DISPATCH = 4'd2;
    localparam t_step ST_CHECK    = 4'd3;
    localparam t_step ST_READ     = 4'd4;
    localparam t_step ST_WALK     = 4'd5;
    localparam t_step ST_CSTART   = 4'd6;
    localparam t_step ST_CREAD    = 4'd7;
    localparam t_step ST_CWRITE   = 4'd8;
    localparam t_step ST_FDONE    = 4'd9;
    localparam t_step ST_CMP      = 4'd10;
    localparam t_step ST_LINK     = 4'd11;
    localparam t_step ST_RANK     = 4'd12;
    localparam t_step ST_CLEAR    = 4'd13;
    localparam t_step ST_DONE     = 4'd14;
    localparam t_step ST_SPARE    = 4'd15;

    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_IN,
        WAIT_OUT,
        WAIT_SWEEP
    } t_wait;

    typedef enum logic [3:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_CLEAR,
        JC_INVALID,
        JC_NOT_ROOT,
        JC_AT_ROOT,
        JC_SIDE_A,
        JC_SAME_ROOT,
        JC_A_HIGHER
    } t_jcond;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_START,
        OP_WALK,
        OP_CSTART,
        OP_CSTEP,
        OP_SAVE,
        OP_CLS_CYCLE,
        OP_CLS_FOREST,
        OP_CLS_CLEAR,
        OP_EMIT
    } t_dp_op;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_READ,
        MEM_CLEAR,
        MEM_COMPRESS,
        MEM_LINK,
        MEM_RANK
    } t_mem_op;

    typedef struct packed {
        t_wait   wt;
        t_jcond  jc;
        t_step   target;
        t_dp_op  op;
        t_mem_op mem;
    } t_uword;

    typedef struct packed {
        logic is_clear;
        logic is_invalid;
        logic not_root;
        logic at_root;
        logic side_a;
        logic same_root;
        logic a_higher;
        logic sweep_last;
    } t_dp_flags;

    typedef struct packed {
        logic      in_valid;
        logic      out_free;
        t_dp_flags dp;
    } t_status;

    typedef struct packed {
        logic    in_ready;
        t_dp_op  op;
        t_mem_op mem;
    } t_ctrl;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [INDEX_W-1:0] idx;
    } t_result;

    // Microprogram. A step holds while its wait condition is open, then
    // jumps to its target when the jump condition is true, else moves on.
    function automatic t_uword kufec_rom(input t_step step);
        t_uword w;
        w = '{wt: WAIT_NONE, jc: JC_NEVER, target: ST_IDLE, op: OP_NONE, mem: MEM_NONE};
        case (step)
            ST_BOOT: begin
                w.wt  = WAIT_SWEEP;
                w.mem = MEM_CLEAR;
            end
            ST_IDLE: begin
                w.wt = WAIT_IN;
                w.op = OP_LATCH;
            end
            ST_DISPATCH: begin
                w.op     = OP_START;
                w.jc     = JC_CLEAR;
                w.target = ST_CLEAR;
            end
            ST_CHECK: begin
                w.jc     = JC_INVALID;
                w.target = ST_DONE;
            end
            ST_READ: begin
                w.mem = MEM_READ;
            end
            ST_WALK: begin
                w.op     = OP_WALK;
                w.jc     = JC_NOT_ROOT;
                w.target = ST_READ;
            end
            ST_CSTART: begin
                w.op = OP_CSTART;
            end
            ST_CREAD: begin
                w.mem    = MEM_READ;
                w.jc     = JC_AT_ROOT;
                w.target = ST_FDONE;
            end
            ST_CWRITE: begin
                w.mem    = MEM_COMPRESS;
                w.op     = OP_CSTEP;
                w.jc     = JC_ALWAYS;
                w.target = ST_CREAD;
            end
            ST_FDONE: begin
                w.op     = OP_SAVE;
                w.jc     = JC_SIDE_A;
                w.target = ST_READ;
            end
            ST_CMP: begin
                w.op     = OP_CLS_CYCLE;
                w.jc     = JC_SAME_ROOT;
                w.target = ST_DONE;
            end
            ST_LINK: begin
                w.op     = OP_CLS_FOREST;
                w.mem    = MEM_LINK;
                w.jc     = JC_A_HIGHER;
                w.target = ST_DONE;
            end
            ST_RANK: begin
                w.mem    = MEM_RANK;
                w.jc     = JC_ALWAYS;
                w.target = ST_DONE;
            end
            ST_CLEAR: begin
                w.wt  = WAIT_SWEEP;
                w.op  = OP_CLS_CLEAR;
                w.mem = MEM_CLEAR;
            end
            ST_DONE: begin
                w.wt     = WAIT_OUT;
                w.op     = OP_EMIT;
                w.jc     = JC_ALWAYS;
                w.target = ST_IDLE;
            end
            default: begin
                w.jc     = JC_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== sv/kufec_if.sv =====
`default_nettype none

interface kufec_in_if;
    import kufec_pkg::*;

    logic                valid;
    logic                ready;
    logic                operation;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
    logic [INDEX_W-1:0]  edge_index;

    modport source (output valid, output operation, output vertex_a, output vertex_b,
                    output edge_index, input ready);
    modport sink (input valid, input operation, input vertex_a, input vertex_b,
                  input edge_index, output ready);
endinterface

interface kufec_out_if;
    import kufec_pkg::*;

    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] edge_class;
    logic [INDEX_W-1:0] result_index;

    modport source (output valid, output edge_class, output result_index, input ready);
    modport sink (input valid, input edge_class, input result_index, output ready);
endinterface

`default_nettype wire

// ===== sv/kruskal_union_find_edge_classifier_unit.sv =====
// Channel   Dir  Payload                                     Transfer
// i_in      in   operation, vertex_a, vertex_b, edge_index   valid && ready
// o_out     out  edge_class, result_index                    valid && ready
// i_cfg_*   in   vertex_count (11 bits)                      i_cfg_we
//
// A valid edge runs through its microprogram steps, each step issuing at most one forest
// memory access; linking two roots takes a link step, plus a rank step when the surviving
// root's rank is rewritten. A clear rewrites every forest entry, one entry per cycle.
// After reset a sweep initializes the forest; no item is taken meanwhile.
// A full output register stalls the sequencer only in its final step.
`default_nettype none

module kruskal_union_find_edge_classifier_unit #(
    parameter int VERTICES = kufec_pkg::VERTICES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    kufec_in_if.sink                             i_in,
    kufec_out_if.source                          o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [kufec_pkg::VCOUNT_W-1:0]  i_cfg_wdata
);
    import kufec_pkg::*;

    t_ctrl              ctrl;
    t_status            stat;
    t_dp_flags          flags;
    t_result            result;
    logic               out_free;
    logic               emit;
    logic               fire;
    logic [VCOUNT_W-1:0] r_vcount;
    logic               r_out_valid;
    t_result            r_out;

    assign out_free = !r_out_valid || o_out.ready;
    assign emit     = (ctrl.op == OP_EMIT) && out_free;
    assign fire     = i_in.valid && ctrl.in_ready;

    assign stat.in_valid = i_in.valid;
    assign stat.out_free = out_free;
    assign stat.dp       = flags;

    kufec_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    kufec_dp #(
        .VERTICES (VERTICES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_fire   (fire),
        .i_in_op  (i_in.operation),
        .i_in_a   (i_in.vertex_a),
        .i_in_b   (i_in.vertex_b),
        .i_in_idx (i_in.edge_index),
        .i_vcount (r_vcount),
        .o_flags  (flags),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RESET;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= result;
        end
    end

    assign i_in.ready         = ctrl.in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.edge_class   = r_out.cls;
    assign o_out.result_index = r_out.idx;

endmodule

`default_nettype wire

// ===== sv/kufec_seq.sv =====
`default_nettype none

module kufec_seq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire kufec_pkg::t_status i_stat,
    output kufec_pkg::t_ctrl      o_ctrl
);
    import kufec_pkg::*;

    `include "assert_macros.svh"

    t_step  r_step;
    t_step  n_step;
    t_uword w;
    logic   hold;
    logic   jump;

    assign w = kufec_rom(r_step);

    always_comb begin
        case (w.wt)
            WAIT_IN:    hold = !i_stat.in_valid;
            WAIT_OUT:   hold = !i_stat.out_free;
            WAIT_SWEEP: hold = !i_stat.dp.sweep_last;
            default:    hold = 1'b0;
        endcase
    end

    always_comb begin
        case (w.jc)
            JC_ALWAYS:    jump = 1'b1;
            JC_CLEAR:     jump = i_stat.dp.is_clear;
            JC_INVALID:   jump = i_stat.dp.is_invalid;
            JC_NOT_ROOT:  jump = i_stat.dp.not_root;
            JC_AT_ROOT:   jump = i_stat.dp.at_root;
            JC_SIDE_A:    jump = i_stat.dp.side_a;
            JC_SAME_ROOT: jump = i_stat.dp.same_root;
            JC_A_HIGHER:  jump = i_stat.dp.a_higher;
            default:      jump = 1'b0;
        endcase
    end

    always_comb begin
        if (hold) begin
            n_step = r_step;
        end else if (jump) begin
            n_step = w.target;
        end else begin
            n_step = t_step'(r_step + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_BOOT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl.in_ready = (w.wt == WAIT_IN);
    assign o_ctrl.op       = w.op;
    assign o_ctrl.mem      = w.mem;

    `ASSERT_NEXT(a_accept_dispatch, i_stat.in_valid && o_ctrl.in_ready,
        r_step == ST_DISPATCH, "accepted item did not go to dispatch")
    `ASSERT_ALWAYS(a_no_spare, r_step != ST_SPARE, "sequencer reached the unused step")
    `ASSERT_NEXT(a_boot_exit, r_step == ST_BOOT,
        r_step == ST_BOOT || r_step == ST_IDLE, "boot sweep left to a wrong step")
    `ASSERT_NEXT(a_done_hold, r_step == ST_DONE && !i_stat.out_free,
        r_step == ST_DONE, "result step left while output register was full")

endmodule

`default_nettype wire

// ===== sv/kufec_dp.sv =====
`default_nettype none

module kufec_dp #(
    parameter int VERTICES = kufec_pkg::VERTICES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire kufec_pkg::t_ctrl                  i_ctrl,
    input  wire logic                              i_fire,
    input  wire logic                              i_in_op,
    input  wire logic [kufec_pkg::VERTEX_W-1:0]    i_in_a,
    input  wire logic [kufec_pkg::VERTEX_W-1:0]    i_in_b,
    input  wire logic [kufec_pkg::INDEX_W-1:0]     i_in_idx,
    input  wire logic [kufec_pkg::VCOUNT_W-1:0]    i_vcount,
    output kufec_pkg::t_dp_flags                   o_flags,
    output kufec_pkg::t_result                     o_result
);
    import kufec_pkg::*;

    localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [VW-1:0]     parent;
    } t_node;

    // Parent and rank of each vertex; the rank is only meaningful at a root.
    t_node mem [VERTICES];

    logic                r_op;
    logic [VERTEX_W-1:0] r_a;
    logic [VERTEX_W-1:0] r_b;
    logic [INDEX_W-1:0]  r_idx;
    logic [CLASS_W-1:0]  r_cls;
    logic [VW-1:0]       r_cur;
    logic [VW-1:0]       r_root;
    logic [RANK_W-1:0]   r_rk;
    logic                r_side;
    logic [VW-1:0]       r_ra;
    logic [VW-1:0]       r_rb;
    logic [RANK_W-1:0]   r_rka;
    logic [RANK_W-1:0]   r_rkb;
    logic [VW-1:0]       r_cnt;
    t_node               r_rd;

    logic [VW-1:0]       mem_addr;
    t_node               mem_wdata;
    logic                mem_we;
    logic                sweep_last;
    logic [RANK_W-1:0]   rank_up;

    assign sweep_last = (r_cnt == VW'(VERTICES - 1));
    assign rank_up = ((r_rka == r_rkb) && (r_rkb != RANK_MAX)) ?
                     RANK_W'(r_rkb + 4'd1) : r_rkb;

    always_comb begin
        mem_addr  = r_cur;
        mem_wdata = '{rank: '0, parent: r_root};
        mem_we    = 1'b0;
        case (i_ctrl.mem)
            MEM_CLEAR: begin
                mem_addr  = r_cnt;
                mem_wdata = '{rank: '0, parent: r_cnt};
                mem_we    = 1'b1;
            end
            MEM_COMPRESS: begin
                mem_we = 1'b1;
            end
            MEM_LINK: begin
                // The lower-ranked root hangs below the other one; on a tie, a's root goes below b's.
                mem_we = 1'b1;
                if (r_rka > r_rkb) begin
                    mem_addr  = r_rb;
                    mem_wdata = '{rank: '0, parent: r_ra};
                end else begin
                    mem_addr  = r_ra;
                    mem_wdata = '{rank: '0, parent: r_rb};
                end
            end
            MEM_RANK: begin
                mem_addr  = r_rb;
                mem_wdata = '{rank: rank_up, parent: r_rb};
                mem_we    = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (i_ctrl.mem == MEM_READ) begin
            r_rd <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.mem == MEM_CLEAR) begin
            r_cnt <= sweep_last ? '0 : VW'(r_cnt + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_LATCH: begin
                if (i_fire) begin
                    r_op  <= i_in_op;
                    r_a   <= i_in_a;
                    r_b   <= i_in_b;
                    r_idx <= i_in_idx;
                end
            end
            OP_START: begin
                r_cur  <= VW'(r_a);
                r_side <= 1'b0;
                r_cls  <= CLS_INVALID;
            end
            OP_WALK: begin
                // At a root the parent equals the vertex, so r_cur holds.
                r_cur  <= r_rd.parent;
                r_root <= r_cur;
                r_rk   <= r_rd.rank;
            end
            OP_CSTART: begin
                r_cur <= r_side ? VW'(r_b) : VW'(r_a);
            end
            OP_CSTEP: begin
                r_cur <= r_rd.parent;
            end
            OP_SAVE: begin
                if (!r_side) begin
                    r_ra   <= r_root;
                    r_rka  <= r_rk;
                    r_cur  <= VW'(r_b);
                    r_side <= 1'b1;
                end else begin
                    r_rb  <= r_root;
                    r_rkb <= r_rk;
                end
            end
            OP_CLS_CYCLE:  r_cls <= CLS_CYCLE;
            OP_CLS_FOREST: r_cls <= CLS_FOREST;
            OP_CLS_CLEAR:  r_cls <= CLS_CLEAR;
            default: begin
            end
        endcase
    end

    assign o_flags.is_clear   = r_op;
    assign o_flags.is_invalid = ({1'b0, r_a} >= i_vcount) || ({1'b0, r_b} >= i_vcount) ||
                                (int'(r_a) >= VERTICES) || (int'(r_b) >= VERTICES);
    assign o_flags.not_root   = (r_rd.parent != r_cur);
    assign o_flags.at_root    = (r_cur == r_root);
    assign o_flags.side_a     = !r_side;
    assign o_flags.same_root  = (r_ra == r_rb);
    assign o_flags.a_higher   = (r_rka > r_rkb);
    assign o_flags.sweep_last = sweep_last;

    assign o_result.cls = r_cls;
    assign o_result.idx = r_idx;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none

module testbench;

    import kufec_pkg::*;

    localparam int VERTICES        = VERTICES_DEF;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int PRESSURE_CYCLES = 400;
    localparam int NUM_PHASES      = 7;
    localparam int EDGES_PER_PHASE = 215;
    localparam int MAX_REPORTS     = 10;

    localparam logic EDGE_OP_CLASSIFY = 1'b0;
    localparam logic EDGE_OP_CLEAR    = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
        logic [INDEX_W-1:0]  edge_index;
    } t_edge_item;

    typedef struct packed {
        logic [CLASS_W-1:0] edge_class;
        logic [INDEX_W-1:0] result_index;
    } t_edge_result;

    typedef enum logic {
        ROW_EDGE,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        logic [VCOUNT_W-1:0] vcount;
        t_edge_item          item;
        logic                known;
        logic [CLASS_W-1:0]  cls;
    } t_directed_row;

    localparam int NUM_DIRECTED = 25;

    // Rows with known set carry a class that follows directly from the
    // setup; the rest are left to the predictor.
    localparam t_directed_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLASSIFY, 10'd0,    10'd1,    16'h0000}, 1'b1, CLS_FOREST},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLASSIFY, 10'd1,    10'd0,    16'h0001}, 1'b1, CLS_CYCLE},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLASSIFY, 10'd1023, 10'd1023, 16'hFFFF}, 1'b1, CLS_CYCLE},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLASSIFY, 10'd1023, 10'd0,    16'h8000}, 1'b1, CLS_FOREST},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLASSIFY, 10'd512,  10'd513,  16'h0002}, 1'b0, CLS_FOREST},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLASSIFY, 10'd513,  10'd1,    16'h0003}, 1'b0, CLS_FOREST},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLASSIFY, 10'd512,  10'd0,    16'h0004}, 1'b0, CLS_FOREST},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLEAR,    10'd1023, 10'd0,    16'h0005}, 1'b1, CLS_CLEAR},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLASSIFY, 10'd0,    10'd1,    16'h0006}, 1'b1, CLS_FOREST},
        '{ROW_CFG,  11'd0,    '{EDGE_OP_CLASSIFY, 10'd0,    10'd0,    16'h0000}, 1'b0, CLS_FOREST},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLASSIFY, 10'd0,    10'd0,    16'h0007}, 1'b1, CLS_INVALID},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLASSIFY, 10'd1023, 10'd5,    16'hAAAA}, 1'b1, CLS_INVALID},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLEAR,    10'd0,    10'd0,    16'h5555}, 1'b1, CLS_CLEAR},
        '{ROW_CFG,  11'd1,    '{EDGE_OP_CLASSIFY, 10'd0,    10'd0,    16'h0000}, 1'b0, CLS_FOREST},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLASSIFY, 10'd0,    10'd0,    16'h0008}, 1'b1, CLS_CYCLE},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLASSIFY, 10'd0,    10'd1,    16'h0009}, 1'b1, CLS_INVALID},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLASSIFY, 10'd1,    10'd0,    16'h000A}, 1'b1, CLS_INVALID},
        '{ROW_CFG,  11'd2047, '{EDGE_OP_CLASSIFY, 10'd0,    10'd0,    16'h0000}, 1'b0, CLS_FOREST},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLASSIFY, 10'd1023, 10'd0,    16'h000B}, 1'b1, CLS_FOREST},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLASSIFY, 10'd0,    10'd1023, 16'h000C}, 1'b1, CLS_CYCLE},
        '{ROW_CFG,  11'd1023, '{EDGE_OP_CLASSIFY, 10'd0,    10'd0,    16'h0000}, 1'b0, CLS_FOREST},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLASSIFY, 10'd1023, 10'd1,    16'h000D}, 1'b1, CLS_INVALID},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLASSIFY, 10'd1022, 10'd1021, 16'h000E}, 1'b0, CLS_FOREST},
        '{ROW_CFG,  11'd1024, '{EDGE_OP_CLASSIFY, 10'd0,    10'd0,    16'h0000}, 1'b0, CLS_FOREST},
        '{ROW_EDGE, 11'd0,    '{EDGE_OP_CLASSIFY, 10'd1023, 10'd1022, 16'h000F}, 1'b0, CLS_FOREST}
    };

    localparam logic [VCOUNT_W-1:0] PHASE_VCOUNT [NUM_PHASES] = '{
        11'd1024, 11'd12, 11'd2047, 11'd200, 11'd2, 11'd1024, 11'd0
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [VCOUNT_W-1:0] cfg_wdata;

    kufec_in_if  edge_in ();
    kufec_out_if class_out ();

    kruskal_union_find_edge_classifier_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (edge_in),
        .o_out       (class_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Shadow of the disjoint-set forest and the vertex count register.
    logic [VERTEX_W-1:0] forest_parent [VERTICES];
    logic [RANK_W-1:0]   forest_rank   [VERTICES];
    logic [VCOUNT_W-1:0] model_vcount;

    t_edge_result awaited_classes [$];
    int unsigned  mismatch_count;
    int           burst_left;
    bit           hold_request;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reset_forest();
        for (int v = 0; v < VERTICES; v++) begin
            forest_parent[v] = VERTEX_W'(v);
            forest_rank[v]   = '0;
        end
    endfunction

    // Root lookup with full path compression.
    function automatic logic [VERTEX_W-1:0] find_root(input logic [VERTEX_W-1:0] v);
        logic [VERTEX_W-1:0] r;
        logic [VERTEX_W-1:0] nxt;
        int                  steps;
        r     = v;
        steps = 0;
        while (forest_parent[r] != r && steps < VERTICES) begin
            r = forest_parent[r];
            steps++;
        end
        steps = 0;
        while (v != r && steps < VERTICES) begin
            nxt              = forest_parent[v];
            forest_parent[v] = r;
            v                = nxt;
            steps++;
        end
        return r;
    endfunction

    function automatic logic [CLASS_W-1:0] classify_edge(input t_edge_item e);
        logic [VERTEX_W-1:0] ra;
        logic [VERTEX_W-1:0] rb;
        if (e.operation == EDGE_OP_CLEAR) begin
            reset_forest();
            return CLS_CLEAR;
        end
        if (VCOUNT_W'(e.vertex_a) >= model_vcount || VCOUNT_W'(e.vertex_b) >= model_vcount) begin
            return CLS_INVALID;
        end
        ra = find_root(e.vertex_a);
        rb = find_root(e.vertex_b);
        if (ra == rb) begin
            return CLS_CYCLE;
        end
        // Union by rank; the rank saturates at its maximum.
        if (forest_rank[ra] > forest_rank[rb]) begin
            forest_parent[rb] = ra;
        end else begin
            forest_parent[ra] = rb;
            if (forest_rank[ra] == forest_rank[rb] && forest_rank[rb] < RANK_MAX) begin
                forest_rank[rb] = forest_rank[rb] + 1'b1;
            end
        end
        return CLS_FOREST;
    endfunction

    function automatic int pick_sender_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 6) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    // Mostly well-formed edges inside the vertex range, with some clears,
    // edges just past the range and fully random endpoints mixed in.
    function automatic t_edge_item random_edge();
        t_edge_item e;
        int         span;
        int         r;
        span         = (int'(model_vcount) > VERTICES) ? VERTICES : int'(model_vcount);
        r            = $urandom_range(0, 99);
        e.operation  = EDGE_OP_CLASSIFY;
        e.edge_index = INDEX_W'($urandom);
        e.vertex_a   = VERTEX_W'($urandom);
        e.vertex_b   = VERTEX_W'($urandom);
        if (r < 3) begin
            e.operation = EDGE_OP_CLEAR;
        end else if (r < 8 && span < VERTICES) begin
            e.vertex_b = VERTEX_W'(span);
        end else if (r >= 15 && span > 0) begin
            e.vertex_a = VERTEX_W'($urandom_range(0, span - 1));
            e.vertex_b = (r < 20) ? e.vertex_a : VERTEX_W'($urandom_range(0, span - 1));
        end
        return e;
    endfunction

    task automatic send_edge(input t_edge_item item, input logic known,
                             input logic [CLASS_W-1:0] known_cls);
        int           gap;
        t_edge_result res;
        gap = pick_sender_gap();
        if (gap > 0) begin
            edge_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        edge_in.valid      <= 1'b1;
        edge_in.operation  <= item.operation;
        edge_in.vertex_a   <= item.vertex_a;
        edge_in.vertex_b   <= item.vertex_b;
        edge_in.edge_index <= item.edge_index;
        @(posedge i_clk);
        while (edge_in.ready !== 1'b1) @(posedge i_clk);
        res.edge_class   = classify_edge(item);
        res.result_index = item.edge_index;
        if (known) res.edge_class = known_cls;
        awaited_classes.push_back(res);
    endtask

    // The register may only change once the block has gone idle.
    task automatic write_vertex_count(input logic [VCOUNT_W-1:0] value);
        edge_in.valid <= 1'b0;
        while (awaited_classes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we       <= 1'b0;
        model_vcount  = value;
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
    endtask

    // Result side: check every transfer, then decide on ready.
    initial begin : result_sink
        int           sink_hold;
        int           free_run;
        int           r;
        t_edge_result exp_res;
        sink_hold = 0;
        free_run  = 0;
        class_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (class_out.valid === 1'b1 && class_out.ready === 1'b1) begin
                if (awaited_classes.size() == 0) begin
                    report_mismatch($sformatf("unexpected result: class %0d index %h",
                                              class_out.edge_class, class_out.result_index));
                end else begin
                    exp_res = awaited_classes.pop_front();
                    if (class_out.edge_class !== exp_res.edge_class ||
                        class_out.result_index !== exp_res.result_index) begin
                        report_mismatch($sformatf(
                            "mismatch: class exp %0d got %0d, index exp %h got %h",
                            exp_res.edge_class, class_out.edge_class,
                            exp_res.result_index, class_out.result_index));
                    end
                end
            end
            if (hold_request) begin
                sink_hold    = PRESSURE_CYCLES;
                hold_request = 1'b0;
            end
            if (sink_hold > 0) begin
                class_out.ready <= 1'b0;
                sink_hold--;
            end else begin
                class_out.ready <= 1'b1;
                if (free_run > 0) begin
                    free_run--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 5) free_run = 200;
                    else if (r >= 55 && r < 92) sink_hold = $urandom_range(1, 3);
                    else if (r >= 92) sink_hold = $urandom_range(8, 40);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((edge_in.valid && edge_in.ready) || (class_out.valid && class_out.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [VCOUNT_W-1:0] vc;
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        edge_in.valid      <= 1'b0;
        edge_in.operation  <= EDGE_OP_CLASSIFY;
        edge_in.vertex_a   <= '0;
        edge_in.vertex_b   <= '0;
        edge_in.edge_index <= '0;
        mismatch_count = 0;
        burst_left     = 0;
        hold_request   = 1'b0;
        model_vcount   = VCOUNT_RESET;
        reset_forest();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
                write_vertex_count(DIRECTED_ROWS[i].vcount);
            end else begin
                send_edge(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].cls);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            vc = (p == NUM_PHASES - 1) ? VCOUNT_W'($urandom_range(1, 2047)) : PHASE_VCOUNT[p];
            write_vertex_count(vc);
            for (int n = 0; n < EDGES_PER_PHASE; n++) begin
                // Hold the result side off while edges keep coming, so the
                // block backs up and stalls its input.
                if (p == 1 && n == 50) begin
                    hold_request = 1'b1;
                    burst_left   = 60;
                end
                send_edge(random_edge(), 1'b0, CLS_FOREST);
            end
        end

        edge_in.valid <= 1'b0;
        while (awaited_classes.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_classes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/kufec_pkg.sv
sv/kufec_if.sv
sv/kufec_seq.sv
sv/kufec_dp.sv
sv/kruskal_union_find_edge_classifier_unit.sv
sim/testbench.sv
